// File: rtl/wllh_pkg.sv
// Shared types and constants for the wait latency log2 histogram block.
`timescale 1ns / 1ps
package wllh_pkg;

    // Event codes on the action field
    localparam logic [1:0] ACT_WAKE   = 2'd0;
    localparam logic [1:0] ACT_SWITCH = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_RECORDED = 3'd1;
    localparam logic [2:0] ST_NO_STAMP = 3'd2;
    localparam logic [2:0] ST_NEGATIVE = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_FILTERED = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_CG_EN  = 2'd0;
    localparam logic [1:0] REG_KEY    = 2'd1;
    localparam logic [1:0] REG_UNIT   = 2'd2;
    localparam logic [1:0] REG_TGID   = 2'd3;

    // Histogram key modes
    localparam logic [1:0] KM_GLOBAL  = 2'd0;
    localparam logic [1:0] KM_PROCESS = 2'd1;
    localparam logic [1:0] KM_THREAD  = 2'd2;
    localparam logic [1:0] KM_NS      = 2'd3;

    localparam logic [31:0] GLOBAL_KEY = 32'hFFFF_FFFF;
    localparam logic [63:0] DIV_US     = 64'd1000;
    localparam logic [63:0] DIV_MS     = 64'd1000000;

    // Work class decided by the front end
    typedef enum logic [1:0] {
        OP_DONE,
        OP_WAKE,
        OP_SWITCH,
        OP_READ
    } t_op;

    // Classified word passed from front to back
    typedef struct packed {
        t_op         op;
        logic [2:0]  status;
        logic        store_en;
        logic [21:0] q_pid;
        logic [63:0] now;
        logic [21:0] n_pid;
        logic [31:0] key;
        logic [4:0]  slot;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic        found;
        logic [31:0] count;
    } t_res;

    // Stamp table entry
    typedef struct packed {
        logic        valid;
        logic [21:0] tid;
        logic [63:0] ts;
    } t_stamp;

    // Histogram key table entry
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
    } t_hkey;

endpackage

// File: rtl/wllh_front.sv
// Front end: filters events and classifies them into back-end words.
`timescale 1ns / 1ps
module wllh_front import wllh_pkg::*; (
    input  logic [1:0]  i_action,
    input  logic [63:0] i_now_ns,
    input  logic        i_in_cgroup,
    input  logic [21:0] i_queued_tgid,
    input  logic [21:0] i_queued_pid,
    input  logic        i_prev_was_running,
    input  logic [21:0] i_next_pid,
    input  logic [21:0] i_next_tgid,
    input  logic [31:0] i_next_ns_id,
    input  logic [31:0] i_read_key,
    input  logic [4:0]  i_read_slot,
    input  logic        i_cg_en,
    input  logic [1:0]  i_key_mode,
    input  logic [21:0] i_tgid_filter,
    output t_cmd        o_cmd
);

    logic w_gate_ok;
    logic w_stamp_ok;
    logic [31:0] w_sw_key;

    assign w_gate_ok  = !i_cg_en || i_in_cgroup;
    assign w_stamp_ok = (i_queued_pid != 22'd0) &&
                        ((i_tgid_filter == 22'd0) || (i_queued_tgid == i_tgid_filter));

    // histogram key for a switch
    always_comb begin
        unique case (i_key_mode)
            KM_PROCESS: w_sw_key = {10'd0, i_next_tgid};
            KM_THREAD:  w_sw_key = {10'd0, i_next_pid};
            KM_NS:      w_sw_key = i_next_ns_id;
            default:    w_sw_key = GLOBAL_KEY;
        endcase
    end

    // classification
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_DONE;
        o_cmd.status   = ST_DONE;
        o_cmd.q_pid    = i_queued_pid;
        o_cmd.now      = i_now_ns;
        o_cmd.n_pid    = i_next_pid;
        o_cmd.slot     = i_read_slot;
        unique case (i_action)
            ACT_WAKE: begin
                if (!w_gate_ok || !w_stamp_ok) begin
                    o_cmd.status = ST_FILTERED;
                end else begin
                    o_cmd.op       = OP_WAKE;
                    o_cmd.store_en = 1'b1;
                end
            end
            ACT_SWITCH: begin
                if (!w_gate_ok) begin
                    o_cmd.status = ST_FILTERED;
                end else begin
                    o_cmd.op       = OP_SWITCH;
                    o_cmd.store_en = i_prev_was_running && w_stamp_ok;
                    o_cmd.key      = w_sw_key;
                end
            end
            ACT_READ: begin
                o_cmd.op  = OP_READ;
                o_cmd.key = i_read_key;
            end
            default: o_cmd.status = ST_DONE;
        endcase
    end

endmodule

// File: rtl/wllh_fifo.sv
// Two-entry queue of classified words between front and back.
`timescale 1ns / 1ps
module wllh_fifo import wllh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!w_push && w_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// File: rtl/wllh_back.sv
// Back end: stamp table, key table, counter memory and the sequencer over them.
`timescale 1ns / 1ps
module wllh_back import wllh_pkg::*; #(
    parameter int STAMP_ENTRIES = 1024,
    parameter int HIST_KEYS     = 64,
    parameter int NUM_SLOTS     = 26
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  logic i_unit_is_ms,
    output t_res o_res,
    output logic o_res_valid,
    input  logic i_res_ready,
    output logic o_clearing
);

    localparam int SIW     = $clog2(STAMP_ENTRIES);
    localparam int HIW     = (HIST_KEYS > 1) ? $clog2(HIST_KEYS) : 1;
    localparam int CW      = ((SIW > HIW) ? SIW : HIW) + 1;
    localparam int CDEPTH  = HIST_KEYS * NUM_SLOTS;
    localparam int CAW     = $clog2(CDEPTH);
    localparam int CLR_LEN = (STAMP_ENTRIES > HIST_KEYS) ? STAMP_ENTRIES : HIST_KEYS;

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_SSCAN = 13'b0000000000100,
        S_SWR   = 13'b0000000001000,
        S_LSCAN = 13'b0000000010000,
        S_LEND  = 13'b0000000100000,
        S_HSCAN = 13'b0000001000000,
        S_HEND  = 13'b0000010000000,
        S_ZERO  = 13'b0000100000000,
        S_DIV   = 13'b0001000000000,
        S_CRD   = 13'b0010000000000,
        S_CUPD  = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    t_res          r_res;
    logic [CW-1:0] r_idx;
    logic          r_pv;
    logic [CW-1:0] r_pidx;
    logic          r_hit;
    logic [CW-1:0] r_hit_idx;
    logic          r_free;
    logic [CW-1:0] r_free_idx;
    logic [63:0]   r_hit_time;
    logic [63:0]   r_delta;
    logic [HIW-1:0] r_hi;
    logic [5:0]    r_slot;
    logic [64:0]   r_thr;
    logic          r_tbl;
    logic [31:0]   r_tgt;

    // memories
    t_stamp        s_mem [STAMP_ENTRIES];
    t_hkey         h_mem [HIST_KEYS];
    logic [31:0]   c_mem [CDEPTH];
    t_stamp        r_sdat;
    t_hkey         r_hdat;
    logic [31:0]   r_cdat;

    logic           s_we;
    logic [SIW-1:0] s_waddr;
    t_stamp         s_wdata;
    logic [SIW-1:0] s_raddr;
    logic           h_we;
    logic [HIW-1:0] h_waddr;
    t_hkey          h_wdata;
    logic [HIW-1:0] h_raddr;
    logic           c_we;
    logic [CAW-1:0] c_addr;
    logic [31:0]    c_wdata;

    logic [CW-1:0] w_lim;
    logic          w_issue;
    logic          w_scan_done;
    logic          w_dvalid;
    logic          w_dmatch;
    logic [63:0]   w_delta;
    logic [64:0]   w_thr0;
    logic          w_div_stop;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;
    assign o_clearing  = (r_state == S_CLR);

    // scan bookkeeping
    assign w_lim       = r_tbl ? CW'(HIST_KEYS) : CW'(STAMP_ENTRIES);
    assign w_issue     = (r_idx < w_lim);
    assign w_scan_done = !w_issue && !r_pv;
    assign w_dvalid    = r_tbl ? r_hdat.valid : r_sdat.valid;
    assign w_dmatch    = r_tbl ? (r_hdat.key == r_tgt) : (r_sdat.tid == r_tgt[21:0]);
    assign s_raddr     = (r_idx < CW'(STAMP_ENTRIES)) ? r_idx[SIW-1:0] : '0;
    assign h_raddr     = (r_idx < CW'(HIST_KEYS)) ? r_idx[HIW-1:0] : '0;

    // latency and bucket search
    assign w_delta    = r_cmd.now - r_hit_time;
    assign w_thr0     = i_unit_is_ms ? {DIV_MS, 1'b0} : {DIV_US, 1'b0};
    assign w_div_stop = (r_slot == 6'(NUM_SLOTS - 1)) || (r_thr > {1'b0, r_delta});
    assign c_addr     = CAW'(CAW'(r_hi) * CAW'(NUM_SLOTS)) + CAW'(r_slot);

    // memory write controls
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_hit_idx[SIW-1:0];
        s_wdata = '0;
        h_we    = 1'b0;
        h_waddr = r_free_idx[HIW-1:0];
        h_wdata = '0;
        c_we    = 1'b0;
        c_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                s_we    = (r_idx < CW'(STAMP_ENTRIES));
                s_waddr = s_raddr;
                h_we    = (r_idx < CW'(HIST_KEYS));
                h_waddr = h_raddr;
            end
            S_SWR: begin
                s_wdata = '{valid: 1'b1, tid: r_cmd.q_pid, ts: r_cmd.now};
                if (r_hit) begin
                    s_we = 1'b1;
                end else if (r_free) begin
                    s_we    = 1'b1;
                    s_waddr = r_free_idx[SIW-1:0];
                end
            end
            S_LEND: s_we = r_hit;
            S_HEND: begin
                h_we    = (r_cmd.op == OP_SWITCH) && !r_hit && r_free;
                h_wdata = '{valid: 1'b1, key: r_cmd.key};
            end
            S_ZERO: c_we = 1'b1;
            S_CUPD: begin
                c_we    = (r_cmd.op == OP_SWITCH);
                c_wdata = r_cdat + 32'd1;
            end
            default: ;
        endcase
    end

    // stamp table
    always_ff @(posedge i_clk) begin
        if (s_we) s_mem[s_waddr] <= s_wdata;
        r_sdat <= s_mem[s_raddr];
    end

    // key table
    always_ff @(posedge i_clk) begin
        if (h_we) h_mem[h_waddr] <= h_wdata;
        r_hdat <= h_mem[h_raddr];
    end

    // counter memory
    always_ff @(posedge i_clk) begin
        if (c_we) c_mem[c_addr] <= c_wdata;
        r_cdat <= c_mem[c_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_tbl   <= 1'b0;
        end else begin
            unique case (r_state)
                // clearing pass over both tables
                S_CLR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == CW'(CLR_LEN - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_idx  <= '0;
                        r_pv   <= 1'b0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        unique case (i_cmd.op)
                            OP_DONE: begin
                                r_res   <= '{status: i_cmd.status, slot: 5'd0,
                                             found: 1'b0, count: 32'd0};
                                r_state <= S_RESP;
                            end
                            OP_WAKE: begin
                                r_tbl   <= 1'b0;
                                r_tgt   <= {10'd0, i_cmd.q_pid};
                                r_state <= S_SSCAN;
                            end
                            OP_SWITCH: begin
                                r_tbl <= 1'b0;
                                if (i_cmd.store_en) begin
                                    r_tgt   <= {10'd0, i_cmd.q_pid};
                                    r_state <= S_SSCAN;
                                end else begin
                                    r_tgt   <= {10'd0, i_cmd.n_pid};
                                    r_state <= S_LSCAN;
                                end
                            end
                            default: begin
                                r_tbl   <= 1'b1;
                                r_tgt   <= i_cmd.key;
                                r_state <= S_HSCAN;
                            end
                        endcase
                    end
                end
                // linear table scan, one entry a cycle
                S_SSCAN, S_LSCAN, S_HSCAN: begin
                    if (w_issue) r_idx <= r_idx + CW'(1);
                    r_pv   <= w_issue;
                    r_pidx <= r_idx;
                    if (r_pv) begin
                        if (w_dvalid && w_dmatch && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_pidx;
                            r_hit_time <= r_sdat.ts;
                        end
                        if (!w_dvalid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                    end
                    if (w_scan_done) begin
                        if (r_state == S_SSCAN)      r_state <= S_SWR;
                        else if (r_state == S_LSCAN) r_state <= S_LEND;
                        else                         r_state <= S_HEND;
                    end
                end
                // stamp written when a matching or free entry exists; wake done, switch goes on to the lookup
                S_SWR: begin
                    if (r_cmd.op == OP_WAKE) begin
                        r_res   <= '{status: ST_DONE, slot: 5'd0, found: 1'b0, count: 32'd0};
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_tgt   <= {10'd0, r_cmd.n_pid};
                        r_state <= S_LSCAN;
                    end
                end
                // incoming stamp found or not; it is removed here
                S_LEND: begin
                    if (!r_hit) begin
                        r_res   <= '{status: ST_NO_STAMP, slot: 5'd0, found: 1'b0,
                                     count: 32'd0};
                        r_state <= S_RESP;
                    end else if (w_delta[63]) begin
                        r_res   <= '{status: ST_NEGATIVE, slot: 5'd0, found: 1'b0,
                                     count: 32'd0};
                        r_state <= S_RESP;
                    end else begin
                        r_delta <= w_delta;
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_tbl   <= 1'b1;
                        r_tgt   <= r_cmd.key;
                        r_state <= S_HSCAN;
                    end
                end
                // key lookup result
                S_HEND: begin
                    r_hi <= r_hit_idx[HIW-1:0];
                    if (r_cmd.op == OP_READ) begin
                        r_slot <= {1'b0, r_cmd.slot};
                        if (!r_hit) begin
                            r_res   <= '{status: ST_READ, slot: 5'd0, found: 1'b0,
                                         count: 32'd0};
                            r_state <= S_RESP;
                        end else if (7'(r_cmd.slot) < 7'(NUM_SLOTS)) begin
                            r_state <= S_CRD;
                        end else begin
                            r_res   <= '{status: ST_READ, slot: 5'd0, found: 1'b1,
                                         count: 32'd0};
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_slot <= 6'd0;
                        r_thr  <= w_thr0;
                        if (r_hit) begin
                            r_state <= S_DIV;
                        end else if (r_free) begin
                            r_hi    <= r_free_idx[HIW-1:0];
                            r_state <= S_ZERO;
                        end else begin
                            r_res   <= '{status: ST_FULL, slot: 5'd0, found: 1'b0,
                                         count: 32'd0};
                            r_state <= S_RESP;
                        end
                    end
                end
                // new key: clear its counters
                S_ZERO: begin
                    if (r_slot == 6'(NUM_SLOTS - 1)) begin
                        r_slot  <= 6'd0;
                        r_state <= S_DIV;
                    end else begin
                        r_slot <= r_slot + 6'd1;
                    end
                end
                // bucket = largest k with unit * 2^k <= delta
                S_DIV: begin
                    if (w_div_stop) begin
                        r_state <= S_CRD;
                    end else begin
                        r_slot <= r_slot + 6'd1;
                        r_thr  <= {r_thr[63:0], 1'b0};
                    end
                end
                S_CRD: r_state <= S_CUPD;
                S_CUPD: begin
                    if (r_cmd.op == OP_READ) begin
                        r_res <= '{status: ST_READ, slot: 5'd0, found: 1'b1, count: r_cdat};
                    end else begin
                        r_res <= '{status: ST_RECORDED, slot: r_slot[4:0], found: 1'b0,
                                   count: 32'd0};
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/wait_latency_log2_histogram.sv
// Top level: register port, front end, queue, back end and output register.
// Words are handled one at a time: the back end takes a new word only when idle, and
// it scans the stamp and key tables linearly through their single read ports.
// A two-word queue decouples input.
// Reset: synchronous; then a clearing pass over both tables, during which no word
// is accepted (register writes still are).
`timescale 1ns / 1ps
module wait_latency_log2_histogram import wllh_pkg::*; #(
    parameter int STAMP_ENTRIES = 1024,
    parameter int HIST_KEYS     = 64,
    parameter int NUM_SLOTS     = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_now_ns,
    input  logic        i_in_cgroup,
    input  logic [21:0] i_queued_tgid,
    input  logic [21:0] i_queued_pid,
    input  logic        i_prev_was_running,
    input  logic [21:0] i_next_pid,
    input  logic [21:0] i_next_tgid,
    input  logic [31:0] i_next_ns_id,
    input  logic [31:0] i_read_key,
    input  logic [4:0]  i_read_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot_hit,
    output logic        o_read_found,
    output logic [31:0] o_read_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_cg_en;
    logic [1:0]  r_key_mode;
    logic        r_unit_ms;
    logic [21:0] r_tgid_flt;
    logic        r_ovalid;
    t_res        r_ores;

    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_q_full;
    logic w_q_empty;
    logic w_back_ready;
    t_res w_res;
    logic w_res_valid;
    logic w_res_ready;
    logic w_clearing;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cg_en    <= 1'b0;
            r_key_mode <= KM_GLOBAL;
            r_unit_ms  <= 1'b0;
            r_tgid_flt <= 22'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_CG_EN: r_cg_en    <= pwdata[0];
                REG_KEY:   r_key_mode <= pwdata[1:0];
                REG_UNIT:  r_unit_ms  <= pwdata[0];
                REG_TGID:  r_tgid_flt <= pwdata[21:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CG_EN: prdata = {31'd0, r_cg_en};
            REG_KEY:   prdata = {30'd0, r_key_mode};
            REG_UNIT:  prdata = {31'd0, r_unit_ms};
            REG_TGID:  prdata = {10'd0, r_tgid_flt};
            default:   prdata = 32'd0;
        endcase
    end

    // input side
    assign o_ready = !w_q_full && !w_clearing;

    wllh_front u_front (
        .i_action           (i_action),
        .i_now_ns           (i_now_ns),
        .i_in_cgroup        (i_in_cgroup),
        .i_queued_tgid      (i_queued_tgid),
        .i_queued_pid       (i_queued_pid),
        .i_prev_was_running (i_prev_was_running),
        .i_next_pid         (i_next_pid),
        .i_next_tgid        (i_next_tgid),
        .i_next_ns_id       (i_next_ns_id),
        .i_read_key         (i_read_key),
        .i_read_slot        (i_read_slot),
        .i_cg_en            (r_cg_en),
        .i_key_mode         (r_key_mode),
        .i_tgid_filter      (r_tgid_flt),
        .o_cmd              (w_front_cmd)
    );

    wllh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && o_ready),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_back_ready),
        .o_empty (w_q_empty),
        .o_data  (w_q_cmd)
    );

    wllh_back #(
        .STAMP_ENTRIES (STAMP_ENTRIES),
        .HIST_KEYS     (HIST_KEYS),
        .NUM_SLOTS     (NUM_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_q_cmd),
        .i_cmd_valid  (!w_q_empty),
        .o_cmd_ready  (w_back_ready),
        .i_unit_is_ms (r_unit_ms),
        .o_res        (w_res),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_clearing   (w_clearing)
    );

    // output register
    assign w_res_ready = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_ready) begin
            r_ovalid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) r_ores <= w_res;
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ores.status;
    assign o_slot_hit   = r_ores.slot;
    assign o_read_found = r_ores.found;
    assign o_read_count = r_ores.count;

endmodule

// File: dv/wait_latency_log2_histogram_tb.sv
// Testbench for the wait latency log2 histogram block: directed table, directed gate checks, then random phases.
`timescale 1ns / 1ps
module wait_latency_log2_histogram_tb;
    import wllh_pkg::*;

    localparam int STAMPS = 1024;
    localparam int KEYS   = 64;
    localparam int SLOTS  = 26;

    // One input word
    typedef struct {
        logic [1:0]  action;
        logic [63:0] now;
        logic        in_cg;
        logic [21:0] q_tgid;
        logic [21:0] q_pid;
        logic        prev_run;
        logic [21:0] n_pid;
        logic [21:0] n_tgid;
        logic [31:0] n_ns;
        logic [31:0] r_key;
        logic [4:0]  r_slot;
    } t_event;

    // Directed row: word plus an optional typed-in result
    typedef struct {
        t_event ev;
        bit     fixed;
        t_res   res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = '0;
    logic [63:0] i_now_ns = '0;
    logic        i_in_cgroup = 1'b0;
    logic [21:0] i_queued_tgid = '0;
    logic [21:0] i_queued_pid = '0;
    logic        i_prev_was_running = 1'b0;
    logic [21:0] i_next_pid = '0;
    logic [21:0] i_next_tgid = '0;
    logic [31:0] i_next_ns_id = '0;
    logic [31:0] i_read_key = '0;
    logic [4:0]  i_read_slot = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [4:0]  o_slot_hit;
    logic        o_read_found;
    logic [31:0] o_read_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wait_latency_log2_histogram dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the block: registers, stamp table, histogram
    logic        cg_en;
    logic [1:0]  key_mode;
    logic        unit_ms;
    logic [21:0] tgid_sel;
    bit          sv_valid [STAMPS];
    logic [21:0] sv_tid   [STAMPS];
    logic [63:0] sv_time  [STAMPS];
    bit          hk_valid [KEYS];
    logic [31:0] hk_key   [KEYS];
    logic [31:0] hk_cnt   [KEYS][SLOTS];

    t_res expected_results[$];
    int   errors = 0;
    bit   long_hold = 0;
    logic [63:0] clock_ns = 64'd5000;

    function automatic int find_stamp(logic [21:0] tid);
        for (int i = 0; i < STAMPS; i++)
            if (sv_valid[i] && sv_tid[i] == tid) return i;
        return -1;
    endfunction

    function automatic bit store_stamp(logic [21:0] tgid, logic [21:0] tid, logic [63:0] t);
        int i;
        if (tid == 0) return 0;
        if (tgid_sel != 0 && tgid != tgid_sel) return 0;
        i = find_stamp(tid);
        if (i < 0) begin
            for (i = 0; i < STAMPS; i++)
                if (!sv_valid[i]) break;
            if (i >= STAMPS) return 1;
            sv_valid[i] = 1;
            sv_tid[i] = tid;
        end
        sv_time[i] = t;
        return 1;
    endfunction

    function automatic int find_key(logic [31:0] key);
        for (int i = 0; i < KEYS; i++)
            if (hk_valid[i] && hk_key[i] == key) return i;
        return -1;
    endfunction

    // Apply one event to the shadow state and return its result
    function automatic t_res latency_histogram_step(t_event ev);
        t_res r;
        int si, hi;
        logic [63:0] delta;
        logic [31:0] key;
        int s;
        r = '0;
        if (ev.action == ACT_WAKE) begin
            if ((cg_en && !ev.in_cg) || !store_stamp(ev.q_tgid, ev.q_pid, ev.now))
                r.status = ST_FILTERED;
        end else if (ev.action == ACT_SWITCH) begin
            if (cg_en && !ev.in_cg) begin
                r.status = ST_FILTERED;
            end else begin
                if (ev.prev_run) void'(store_stamp(ev.q_tgid, ev.q_pid, ev.now));
                si = find_stamp(ev.n_pid);
                if (si < 0) begin
                    r.status = ST_NO_STAMP;
                end else begin
                    delta = ev.now - sv_time[si];
                    if (delta[63]) begin
                        r.status = ST_NEGATIVE;
                    end else begin
                        case (key_mode)
                            KM_PROCESS: key = 32'(ev.n_tgid);
                            KM_THREAD:  key = 32'(ev.n_pid);
                            KM_NS:      key = ev.n_ns;
                            default:    key = GLOBAL_KEY;
                        endcase
                        hi = find_key(key);
                        if (hi < 0) begin
                            for (hi = 0; hi < KEYS; hi++)
                                if (!hk_valid[hi]) break;
                            if (hi >= KEYS) begin
                                hi = -1;
                            end else begin
                                hk_valid[hi] = 1;
                                hk_key[hi] = key;
                                for (int k = 0; k < SLOTS; k++) hk_cnt[hi][k] = '0;
                            end
                        end
                        if (hi < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            delta = delta / (unit_ms ? DIV_MS : DIV_US);
                            s = 0;
                            while (delta > 1) begin
                                delta = delta >> 1;
                                s++;
                            end
                            if (s >= SLOTS) s = SLOTS - 1;
                            hk_cnt[hi][s] = hk_cnt[hi][s] + 1;
                            r.status = ST_RECORDED;
                            r.slot = 5'(s);
                        end
                    end
                    sv_valid[si] = 0;
                end
            end
        end else if (ev.action == ACT_READ) begin
            hi = find_key(ev.r_key);
            r.status = ST_READ;
            if (hi >= 0) begin
                r.found = 1;
                if (ev.r_slot < SLOTS) r.count = hk_cnt[hi][ev.r_slot];
            end
        end
        return r;
    endfunction

    // Register write over the APB-style port; shadow follows
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_CG_EN: cg_en = val[0];
            REG_KEY:   key_mode = val[1:0];
            REG_UNIT:  unit_ms = val[0];
            default:   tgid_sel = val[21:0];
        endcase
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic set_config(logic cg, logic [1:0] km, logic ms, logic [21:0] tg);
        reg_write(REG_CG_EN, 32'(cg));
        reg_write(REG_KEY, 32'(km));
        reg_write(REG_UNIT, 32'(ms));
        reg_write(REG_TGID, 32'(tg));
    endtask

    // Present one word; predict at the accepting edge. Caller is at a falling edge.
    task automatic send_word(t_event ev, bit fixed, t_res fixed_res);
        int gap;
        t_res r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_action = ev.action; i_now_ns = ev.now; i_in_cgroup = ev.in_cg;
        i_queued_tgid = ev.q_tgid; i_queued_pid = ev.q_pid;
        i_prev_was_running = ev.prev_run; i_next_pid = ev.n_pid;
        i_next_tgid = ev.n_tgid; i_next_ns_id = ev.n_ns;
        i_read_key = ev.r_key; i_read_slot = ev.r_slot;
        i_valid = 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = latency_histogram_step(ev);
        if (fixed && r != fixed_res)
            $display("%0t: table row result %p disagrees with prediction %p", $time,
                     fixed_res, r);
        expected_results.push_back(fixed ? fixed_res : r);
        @(negedge i_clk);
    endtask

    // Caller is at the falling edge right after the last accepted word
    task automatic drain();
        i_valid = 0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [21:0] pick_pid();
        if ($urandom_range(0, 15) == 0) return 22'($urandom);
        return 22'($urandom_range(1, 48));
    endfunction

    function automatic logic [21:0] pick_tgid();
        case ($urandom_range(0, 4))
            0: return 22'd1;
            1: return 22'd2;
            2: return 22'h3FFFFF;
            3: return 22'($urandom);
            default: return 22'd3;
        endcase
    endfunction

    // Random word; mostly wake/switch pairs on a small thread pool
    function automatic t_event random_word();
        t_event ev;
        int pick;
        ev.action = ACT_WAKE; ev.now = '0; ev.in_cg = ($urandom_range(0, 7) != 0);
        ev.q_tgid = pick_tgid(); ev.q_pid = pick_pid();
        ev.prev_run = 1'($urandom_range(0, 1));
        ev.n_pid = pick_pid(); ev.n_tgid = pick_tgid(); ev.n_ns = $urandom;
        if ($urandom_range(0, 1)) ev.n_ns = 32'($urandom_range(0, 3));
        ev.r_key = $urandom; ev.r_slot = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 38) ev.action = ACT_WAKE;
        else if (pick < 80) ev.action = ACT_SWITCH;
        else if (pick < 95) ev.action = ACT_READ;
        else ev.action = 2'd3;
        case ($urandom_range(0, 3))
            0: ev.r_key = GLOBAL_KEY;
            1: ev.r_key = 32'(ev.n_tgid);
            2: ev.r_key = 32'(ev.n_pid);
            default: ;
        endcase
        // time mostly moves forward in jumps of every scale; sometimes jumps anywhere
        if ($urandom_range(0, 19) == 0)
            clock_ns = {$urandom, $urandom};
        else
            clock_ns = clock_ns + ({$urandom, $urandom} >> $urandom_range(14, 63));
        ev.now = clock_ns;
        return ev;
    endfunction

    function automatic t_event blank_word(logic [1:0] act, logic [63:0] t);
        t_event ev;
        ev.action = act; ev.now = t; ev.in_cg = 1; ev.q_tgid = 22'd1; ev.q_pid = '0;
        ev.prev_run = 0; ev.n_pid = '0; ev.n_tgid = 22'd1; ev.n_ns = '0;
        ev.r_key = GLOBAL_KEY; ev.r_slot = '0;
        return ev;
    endfunction

    function automatic t_res res_of(logic [2:0] st, logic [4:0] sl, logic f, logic [31:0] c);
        t_res r;
        r.status = st; r.slot = sl; r.found = f; r.count = c;
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d found=%0d count=%0d",
                         $time, o_status, o_slot_hit, o_read_found, o_read_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_slot_hit !== want.slot ||
                    o_read_found !== want.found || o_read_count !== want.count) begin
                    $display("%0t: mismatch expected status=%0d slot=%0d found=%0d count=%0d",
                             $time, want.status, want.slot, want.found, want.count);
                    $display("%0t:            actual status=%0d slot=%0d found=%0d count=%0d",
                             $time, o_status, o_slot_hit, o_read_found, o_read_count);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall per word, one long hold-off on request
    initial begin
        int wait_cycles;
        forever begin
            @(negedge i_clk);
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (long_hold) begin
                wait_cycles = 12000;
                long_hold = 0;
            end
            if (wait_cycles > 0) begin
                i_ready = 0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_ready = 1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Run limit
    initial begin
        #400ms;
        $display("Simulation FAILED");
        $finish;
    end

    t_row rows[$];

    initial begin
        t_event ev;
        t_res none;
        none = '0;
        cg_en = 0; key_mode = KM_GLOBAL; unit_ms = 0; tgid_sel = '0;
        for (int i = 0; i < STAMPS; i++) sv_valid[i] = 0;
        for (int i = 0; i < KEYS; i++) hk_valid[i] = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        set_config(0, KM_GLOBAL, 0, '0);

        // Directed table
        ev = blank_word(ACT_READ, 64'd0);
        rows.push_back('{ev, 1, res_of(ST_READ, 0, 0, 0)});
        ev = blank_word(2'd3, 64'd0);
        rows.push_back('{ev, 1, res_of(ST_DONE, 0, 0, 0)});
        ev = blank_word(ACT_WAKE, 64'd0);
        rows.push_back('{ev, 1, res_of(ST_FILTERED, 0, 0, 0)});
        ev = blank_word(ACT_SWITCH, 64'd10); ev.n_pid = 22'd5;
        rows.push_back('{ev, 1, res_of(ST_NO_STAMP, 0, 0, 0)});
        // one microsecond lands in bucket 0
        ev = blank_word(ACT_WAKE, 64'd1000); ev.q_pid = 22'd7;
        rows.push_back('{ev, 1, none});
        ev = blank_word(ACT_SWITCH, 64'd2000); ev.n_pid = 22'd7;
        rows.push_back('{ev, 1, res_of(ST_RECORDED, 0, 0, 0)});
        // wrapped difference counts as negative
        ev = blank_word(ACT_WAKE, 64'd0); ev.q_pid = 22'h3FFFFF; ev.q_tgid = 22'h3FFFFF;
        rows.push_back('{ev, 1, none});
        ev = blank_word(ACT_SWITCH, '1); ev.n_pid = 22'h3FFFFF; ev.n_tgid = 22'h3FFFFF;
        ev.n_ns = '1;
        rows.push_back('{ev, 1, res_of(ST_NEGATIVE, 0, 0, 0)});
        // largest positive delta caps at the top bucket
        ev = blank_word(ACT_WAKE, 64'd0); ev.q_pid = 22'd9;
        rows.push_back('{ev, 1, none});
        ev = blank_word(ACT_SWITCH, 64'h7FFF_FFFF_FFFF_FFFF); ev.n_pid = 22'd9;
        rows.push_back('{ev, 1, res_of(ST_RECORDED, 5'(SLOTS - 1), 0, 0)});
        // stamp consumed: a second switch finds nothing
        ev = blank_word(ACT_SWITCH, 64'd5); ev.n_pid = 22'd9;
        rows.push_back('{ev, 1, res_of(ST_NO_STAMP, 0, 0, 0)});
        // outgoing task stamped on the switch, then picked up by the next one
        ev = blank_word(ACT_SWITCH, 64'd3000); ev.q_pid = 22'd10; ev.prev_run = 1;
        ev.n_pid = 22'd11;
        rows.push_back('{ev, 1, res_of(ST_NO_STAMP, 0, 0, 0)});
        ev = blank_word(ACT_SWITCH, 64'd3000 + 64'd1000 * 64'd100); ev.n_pid = 22'd10;
        rows.push_back('{ev, 0, none});
        // reads: present key, out-of-range slot, absent key
        ev = blank_word(ACT_READ, 64'd0); ev.r_slot = 5'd0;
        rows.push_back('{ev, 1, res_of(ST_READ, 0, 1, 1)});
        ev = blank_word(ACT_READ, 64'd0); ev.r_slot = 5'(SLOTS - 1);
        rows.push_back('{ev, 1, res_of(ST_READ, 0, 1, 1)});
        ev = blank_word(ACT_READ, 64'd0); ev.r_slot = 5'd6;
        rows.push_back('{ev, 0, none});
        ev = blank_word(ACT_READ, 64'd0); ev.r_slot = 5'd31;
        rows.push_back('{ev, 1, res_of(ST_READ, 0, 1, 0)});
        ev = blank_word(ACT_READ, 64'd0); ev.r_key = 32'd0; ev.r_slot = 5'd31;
        rows.push_back('{ev, 1, res_of(ST_READ, 0, 0, 0)});
        ev = blank_word(2'd3, '1); ev.q_pid = 22'h3FFFFF; ev.prev_run = 1; ev.in_cg = 0;
        rows.push_back('{ev, 1, res_of(ST_DONE, 0, 0, 0)});
        foreach (rows[i]) send_word(rows[i].ev, rows[i].fixed, rows[i].res);
        drain();

        // gates: cgroup filter and a tgid filter, directed
        set_config(1, KM_GLOBAL, 0, 22'd2);
        ev = blank_word(ACT_WAKE, 64'd100); ev.q_pid = 22'd20; ev.q_tgid = 22'd2;
        ev.in_cg = 0;
        send_word(ev, 1, res_of(ST_FILTERED, 0, 0, 0));
        ev.in_cg = 1; ev.q_tgid = 22'd3;
        send_word(ev, 1, res_of(ST_FILTERED, 0, 0, 0));
        ev = blank_word(ACT_SWITCH, 64'd200); ev.in_cg = 0; ev.n_pid = 22'd7;
        send_word(ev, 1, res_of(ST_FILTERED, 0, 0, 0));
        ev = blank_word(ACT_READ, 64'd0); ev.in_cg = 0;
        send_word(ev, 0, none);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(0, KM_GLOBAL, 0, '0);
                1: set_config(1, KM_PROCESS, 1, 22'd1);
                2: set_config(0, KM_THREAD, 0, '0);
                3: set_config(1, KM_GLOBAL, 1, 22'h3FFFFF);
                4: set_config(0, KM_NS, 0, '0);
                default: set_config(0, KM_THREAD, 1, 22'd3);
            endcase
            for (int n = 0; n < 80; n++) begin
                if (ph == 0 && n == 10) long_hold = 1;
                send_word(random_word(), 0, none);
            end
            drain();
        end

        repeat (2500) @(negedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
